// ===== rtl/wgtg_pkg.sv =====
// Package: shared types, constants and tables of the waypoint controller
package wgtg_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam logic signed [15:0] PI_Q13     = 16'sd25736;
    localparam logic signed [17:0] TWO_PI_Q13 = 18'sd51472;
    localparam logic signed [47:0] PI_Q24     = 48'sd52707179;
    localparam int DRIVE_ERR_LIMIT  = 4096;
    localparam int TURN_LIMIT       = 3277;
    localparam int ALIGN_TURN_LIMIT = 2048;

    typedef enum logic [1:0] {
        FN_POSE   = 2'd0,
        FN_TICK   = 2'd1,
        FN_CANCEL = 2'd2,
        FN_START  = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_WAIT    = 3'd0,
        ST_DRIVE   = 3'd1,
        ST_ALIGN   = 3'd2,
        ST_REACHED = 3'd3,
        ST_CANCEL  = 3'd4,
        ST_IDLE    = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        PH_TRANSLATE = 2'd0,
        PH_ALIGN     = 2'd1,
        PH_FINISHED  = 2'd2,
        PH_SPARE     = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        REG_TX   = 3'd0,
        REG_TY   = 3'd1,
        REG_TH   = 3'd2,
        REG_PTOL = 3'd3,
        REG_HTOL = 3'd4,
        REG_LG   = 3'd5,
        REG_TG   = 3'd6,
        REG_MAXF = 3'd7
    } t_reg;

    typedef enum logic [3:0] {
        S_IDLE, S_POSE_MUL, S_POSE_SUM, S_CORD_INIT, S_CORD_NORM, S_CORD_RUN,
        S_TICK_DIFF, S_TICK_SQ, S_SQRT_INIT, S_SQRT_RUN, S_TICK_EVAL, S_OUT
    } t_state;

    typedef struct packed {
        logic load_in;
        logic pose_mul;
        logic pose_sum;
        logic cord_init_pose;
        logic cord_init_tick;
        logic cord_norm;
        logic cord_step;
        logic tick_diff;
        logic tick_sq;
        logic sqrt_init;
        logic sqrt_step;
        logic pose_store;
        logic eval;
    } t_cmd;

    typedef struct packed {
        logic norm_done;
        logic cord_done;
        logic sqrt_done;
    } t_sts;

    function automatic logic [47:0] atan_q24(input logic [4:0] i);
        unique case (i)
            5'd0:  atan_q24 = 48'd13176795;
            5'd1:  atan_q24 = 48'd7778716;
            5'd2:  atan_q24 = 48'd4110060;
            5'd3:  atan_q24 = 48'd2086331;
            5'd4:  atan_q24 = 48'd1047214;
            5'd5:  atan_q24 = 48'd524117;
            5'd6:  atan_q24 = 48'd262123;
            5'd7:  atan_q24 = 48'd131069;
            5'd8:  atan_q24 = 48'd65536;
            5'd9:  atan_q24 = 48'd32768;
            5'd10: atan_q24 = 48'd16384;
            5'd11: atan_q24 = 48'd8192;
            5'd12: atan_q24 = 48'd4096;
            5'd13: atan_q24 = 48'd2048;
            5'd14: atan_q24 = 48'd1024;
            5'd15: atan_q24 = 48'd512;
            5'd16: atan_q24 = 48'd256;
            5'd17: atan_q24 = 48'd128;
            5'd18: atan_q24 = 48'd64;
            5'd19: atan_q24 = 48'd32;
            5'd20: atan_q24 = 48'd16;
            5'd21: atan_q24 = 48'd8;
            5'd22: atan_q24 = 48'd4;
            5'd23: atan_q24 = 48'd2;
            default: atan_q24 = 48'd0;
        endcase
    endfunction

    function automatic logic signed [17:0] wrap18(input logic signed [17:0] a);
        if (a > 18'(PI_Q13))
            wrap18 = a - TWO_PI_Q13;
        else if (a < -18'(PI_Q13))
            wrap18 = a + TWO_PI_Q13;
        else
            wrap18 = a;
    endfunction

endpackage

// ===== rtl/wgtg_ctrl.sv =====
// Controller: sequencer of the pose and tick transactions
module wgtg_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [1:0]      i_func,
    input  logic            i_out_busy,
    output logic            o_out_load,
    input  wgtg_pkg::t_sts  i_sts,
    output wgtg_pkg::t_cmd  o_cmd
);
    import wgtg_pkg::*;

    t_state r_state, n_state;
    logic   r_pose, n_pose;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pose  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pose  <= n_pose;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_pose     = r_pose;
        o_cmd      = '0;
        o_out_load = 1'b0;
        o_in_ready = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    unique case (t_func'(i_func))
                        FN_POSE:   begin n_state = S_POSE_MUL; n_pose = 1'b1; end
                        FN_START:  n_state = S_IDLE;
                        FN_TICK, FN_CANCEL: begin
                            n_state = S_TICK_DIFF; n_pose = 1'b0;
                        end
                    endcase
                end
            end
            S_POSE_MUL: begin o_cmd.pose_mul = 1'b1; n_state = S_POSE_SUM; end
            S_POSE_SUM: begin o_cmd.pose_sum = 1'b1; n_state = S_CORD_INIT; end
            S_TICK_DIFF: begin o_cmd.tick_diff = 1'b1; n_state = S_TICK_SQ; end
            S_TICK_SQ: begin o_cmd.tick_sq = 1'b1; n_state = S_SQRT_INIT; end
            S_SQRT_INIT: begin o_cmd.sqrt_init = 1'b1; n_state = S_SQRT_RUN; end
            S_SQRT_RUN: begin
                o_cmd.sqrt_step = 1'b1;
                if (i_sts.sqrt_done) n_state = S_CORD_INIT;
            end
            S_CORD_INIT: begin
                o_cmd.cord_init_pose = r_pose;
                o_cmd.cord_init_tick = !r_pose;
                n_state = S_CORD_NORM;
            end
            S_CORD_NORM: begin
                o_cmd.cord_norm = 1'b1;
                if (i_sts.norm_done) n_state = S_CORD_RUN;
            end
            S_CORD_RUN: begin
                o_cmd.cord_step = 1'b1;
                if (i_sts.cord_done) begin
                    if (r_pose) begin
                        o_cmd.pose_store = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_TICK_EVAL;
                    end
                end
            end
            S_TICK_EVAL: begin o_cmd.eval = 1'b1; n_state = S_OUT; end
            S_OUT: begin
                if (!i_out_busy) begin
                    o_out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== rtl/wgtg_dp.sv =====
// Datapath: pose store, square root, CORDIC vectoring and control law
module wgtg_dp #(
    parameter int CORDIC_STEPS = wgtg_pkg::CORDIC_STEPS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wgtg_pkg::t_cmd      i_cmd,
    output wgtg_pkg::t_sts      o_sts,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_data,
    input  logic [1:0]          i_func,
    input  logic signed [31:0]  i_pos_x,
    input  logic signed [31:0]  i_pos_y,
    input  logic signed [15:0]  i_quat_w,
    input  logic signed [15:0]  i_quat_x,
    input  logic signed [15:0]  i_quat_y,
    input  logic signed [15:0]  i_quat_z,
    output logic [2:0]          o_status,
    output logic [14:0]         o_forward_speed,
    output logic signed [12:0]  o_turn_rate,
    output logic [31:0]         o_distance_left,
    output logic signed [15:0]  o_heading_left,
    output logic signed [31:0]  o_report_x,
    output logic signed [31:0]  o_report_y
);
    import wgtg_pkg::*;

    localparam int STEP_W = $clog2(CORDIC_STEPS + 1);

    // configuration
    logic signed [31:0] r_tx, r_ty;
    logic signed [15:0] r_th;
    logic [15:0] r_ptol, r_lg, r_tg;
    logic [14:0] r_htol, r_maxf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx <= '0; r_ty <= '0; r_th <= '0;
            r_ptol <= 16'd6554; r_htol <= 15'd819;
            r_lg <= 16'd154; r_tg <= 16'd384; r_maxf <= 15'd2048;
        end else if (i_cfg_we) begin
            unique case (t_reg'(i_cfg_idx))
                REG_TX:   r_tx   <= i_cfg_data;
                REG_TY:   r_ty   <= i_cfg_data;
                REG_TH:   r_th   <= i_cfg_data[15:0];
                REG_PTOL: r_ptol <= i_cfg_data[15:0];
                REG_HTOL: r_htol <= i_cfg_data[14:0];
                REG_LG:   r_lg   <= i_cfg_data[15:0];
                REG_TG:   r_tg   <= i_cfg_data[15:0];
                REG_MAXF: r_maxf <= i_cfg_data[14:0];
            endcase
        end
    end

    // state
    logic signed [31:0] r_sx, r_sy;
    logic signed [15:0] r_yaw;
    logic r_seen;
    t_phase r_phase;
    t_phase n_phase;

    // captured item
    logic [1:0] r_func;
    logic signed [31:0] r_px, r_py;
    logic signed [15:0] r_qw, r_qx, r_qy, r_qz;

    // products
    logic signed [31:0] r_p0, r_p1, r_p2, r_p3;
    logic signed [47:0] r_sn, r_cs;

    // tick
    logic signed [32:0] r_dx, r_dy;
    logic [31:0] r_ax, r_ay;
    logic r_half;

    // square root
    logic [63:0] r_rem, r_res, r_bit;
    logic [5:0]  r_sqcnt;

    // CORDIC
    logic signed [47:0] r_cx, r_cy, r_cz;
    logic [STEP_W-1:0]  r_ci;
    logic signed [15:0] r_ang;

    logic [31:0] r_dist;

    // isqrt step
    logic [63:0] w_trial;
    assign w_trial = r_res + r_bit;

    // cordic step
    logic signed [47:0] w_xs, w_ys;
    assign w_xs = r_cx >>> r_ci;
    assign w_ys = r_cy >>> r_ci;

    logic [47:0] w_max;
    logic [47:0] w_abx, w_aby;
    assign w_abx = r_cx[47] ? -r_cx : r_cx;
    assign w_aby = r_cy[47] ? -r_cy : r_cy;
    assign w_max = (w_abx > w_aby) ? w_abx : w_aby;

    assign o_sts.norm_done = (w_max == '0) || w_max[40] || (w_max > 48'h00FF_FFFF_FFFF);
    assign o_sts.cord_done = (r_ci == STEP_W'(CORDIC_STEPS)) || (w_max == '0);
    assign o_sts.sqrt_done = (r_sqcnt == 6'd31);

    logic signed [47:0] w_zr;
    logic signed [17:0] w_ang;
    assign w_zr  = (r_cz + 48'sd1024) >>> 11;
    assign w_ang = wrap18(w_zr[17:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx <= '0; r_sy <= '0; r_yaw <= '0;
            r_seen <= 1'b0;
            r_phase <= PH_TRANSLATE;
        end else begin
            if (i_cmd.load_in && t_func'(i_func) == FN_START)
                r_phase <= PH_TRANSLATE;
            if (i_cmd.pose_store) begin
                r_sx <= r_px; r_sy <= r_py; r_seen <= 1'b1;
                r_yaw <= (w_max == '0) ? 16'sd0 : w_ang[15:0];
            end
            if (i_cmd.eval)
                r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_func <= i_func;
            r_px <= i_pos_x; r_py <= i_pos_y;
            r_qw <= i_quat_w; r_qx <= i_quat_x; r_qy <= i_quat_y; r_qz <= i_quat_z;
        end
        if (i_cmd.pose_mul) begin
            r_p0 <= r_qw * r_qz;
            r_p1 <= r_qx * r_qy;
            r_p2 <= r_qy * r_qy;
            r_p3 <= r_qz * r_qz;
        end
        if (i_cmd.pose_sum) begin
            r_sn <= 48'(r_p0) + 48'(r_p1) <<< 1;
            r_cs <= (48'sd1 <<< 28) - ((48'(r_p2) + 48'(r_p3)) <<< 1);
        end
        if (i_cmd.tick_diff) begin
            r_dx <= 33'(r_tx) - 33'(r_sx);
            r_dy <= 33'(r_ty) - 33'(r_sy);
        end
        if (i_cmd.tick_sq) begin
            logic [32:0] ax, ay;
            ax = r_dx[32] ? 33'(-r_dx) : 33'(r_dx);
            ay = r_dy[32] ? 33'(-r_dy) : 33'(r_dy);
            r_half <= ax[32] || ay[32] || ax[31] || ay[31];
            if (ax[32] || ay[32] || ax[31] || ay[31]) begin
                r_ax <= ax[32:1]; r_ay <= ay[32:1];
            end else begin
                r_ax <= ax[31:0]; r_ay <= ay[31:0];
            end
        end
        if (i_cmd.sqrt_init) begin
            r_rem <= 64'(r_ax) * 64'(r_ax) + 64'(r_ay) * 64'(r_ay);
            r_res <= '0;
            r_bit <= 64'd1 << 62;
            r_sqcnt <= '0;
        end
        if (i_cmd.sqrt_step) begin
            if (r_rem >= w_trial) begin
                r_rem <= r_rem - w_trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
            r_sqcnt <= r_sqcnt + 6'd1;
        end
        if (i_cmd.cord_init_pose) begin
            r_cx <= r_cs; r_cy <= r_sn; r_cz <= '0; r_ci <= '0;
        end
        if (i_cmd.cord_init_tick) begin
            logic [32:0] d;
            r_cx <= 48'(r_dx); r_cy <= 48'(r_dy); r_cz <= '0; r_ci <= '0;
            d = r_half ? {r_res[31:0], 1'b0} : {1'b0, r_res[31:0]};
            r_dist <= (r_half && r_res[32]) || d[32] ? 32'hFFFF_FFFF : d[31:0];
        end
        if (i_cmd.cord_norm && !o_sts.norm_done) begin
            r_cx <= r_cx <<< 1; r_cy <= r_cy <<< 1;
        end
        if (i_cmd.cord_norm && o_sts.norm_done && r_cx[47]) begin
            r_cz <= r_cy[47] ? -PI_Q24 : PI_Q24;
            r_cx <= -r_cx; r_cy <= -r_cy;
        end
        if (i_cmd.cord_step) begin
            if (!o_sts.cord_done) begin
                if (!r_cy[47] && r_cy != '0) begin
                    r_cx <= r_cx + w_ys; r_cy <= r_cy - w_xs;
                    r_cz <= r_cz + atan_q24(5'(r_ci));
                end else begin
                    r_cx <= r_cx - w_ys; r_cy <= r_cy + w_xs;
                    r_cz <= r_cz - atan_q24(5'(r_ci));
                end
                r_ci <= r_ci + STEP_W'(1);
            end
            r_ang <= (w_max == '0) ? 16'sd0 : w_ang[15:0];
        end
    end

    // evaluation
    logic signed [17:0] w_bear, w_yawe;
    logic signed [17:0] w_abe;
    logic [15:0] w_ay;
    logic signed [35:0] w_tp;
    logic signed [35:0] w_tr;
    logic [48:0] w_fp;
    logic [36:0] w_f;
    logic signed [19:0] w_ar;

    always_comb begin
        w_bear = wrap18(18'(r_ang) - 18'(r_yaw));
        w_yawe = wrap18(18'(r_th) - 18'(r_yaw));
        if (!r_seen) begin
            w_bear = '0; w_yawe = '0;
        end
        w_abe = w_yawe[17] ? -w_yawe : w_yawe;
        w_ay  = w_abe[15:0];
        w_tp  = $signed({20'd0, r_tg}) * 36'(w_bear);
        w_tr  = (w_tp + 36'sd256) >>> 9;
        w_fp  = 49'(r_lg) * 49'(r_seen ? r_dist : 32'd0);
        w_f   = 37'((w_fp + 49'd2048) >> 12);
        w_ar  = (20'(w_yawe) * 20'sd3 + 20'sd2) >>> 2;
    end

    t_status n_st;
    logic [14:0] n_fw;
    logic signed [12:0] n_tr;

    always_comb begin
        n_phase = r_phase;
        n_fw = '0;
        n_tr = '0;
        if (t_func'(r_func) == FN_CANCEL) begin
            n_phase = PH_FINISHED; n_st = ST_CANCEL;
        end else if (r_phase == PH_FINISHED || r_phase == PH_SPARE) begin
            n_st = ST_IDLE;
        end else if (!r_seen) begin
            n_st = ST_WAIT;
        end else if (r_phase == PH_TRANSLATE && 32'(r_dist) > 32'(r_ptol)) begin
            n_st = ST_DRIVE;
            if (w_tr > 36'(TURN_LIMIT)) n_tr = 13'(TURN_LIMIT);
            else if (w_tr < -36'(TURN_LIMIT)) n_tr = -13'(TURN_LIMIT);
            else n_tr = w_tr[12:0];
            if (w_bear < 18'(DRIVE_ERR_LIMIT) && w_bear > -18'(DRIVE_ERR_LIMIT))
                n_fw = (w_f > 37'(r_maxf)) ? r_maxf : w_f[14:0];
        end else if (w_ay > 16'(r_htol)) begin
            n_phase = PH_ALIGN; n_st = ST_ALIGN;
            if (w_ar > 20'(ALIGN_TURN_LIMIT)) n_tr = 13'(ALIGN_TURN_LIMIT);
            else if (w_ar < -20'(ALIGN_TURN_LIMIT)) n_tr = -13'(ALIGN_TURN_LIMIT);
            else n_tr = w_ar[12:0];
        end else begin
            n_phase = PH_FINISHED; n_st = ST_REACHED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            o_status        <= n_st;
            o_forward_speed <= n_fw;
            o_turn_rate     <= n_tr;
            o_distance_left <= r_seen ? r_dist : 32'd0;
            o_heading_left  <= w_yawe[15:0];
            o_report_x      <= r_sx;
            o_report_y      <= r_sy;
        end
    end

endmodule

// ===== rtl/waypoint_go_to_goal_controller_top.sv =====
// Top level of the waypoint go-to-goal controller
//
// Input channel (i_in_valid/o_in_ready) carries one transaction: func and a pose.
// Pose transactions derive yaw via CORDIC vectoring and give no result.
// Start transactions reset the phase and give no result.
// Tick and cancel transactions give one result on the output channel.
// Pose: multiply, sum and CORDIC load, normalise (k shifts, 0 to 39), then
// CORDIC_STEPS iterations.
// Tick: difference, square and root load, 32 root iterations, CORDIC load,
// normalise (k shifts, 0 to 40), CORDIC_STEPS iterations, then evaluate and
// load of the result into the output register.
// One transaction is worked on at a time; the input is ready only when idle.
// The result is held in an output register until taken; while the receiver
// stalls, one new transaction may be worked up to the final load.
// Configuration writes take effect at once; write only while idle.
// Reset (synchronous, active low) restores register defaults and clears pose.
module waypoint_go_to_goal_controller_top #(
    parameter int CORDIC_STEPS = wgtg_pkg::CORDIC_STEPS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  logic [1:0]   i_func,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [15:0] i_quat_w,
    input  logic signed [15:0] i_quat_x,
    input  logic signed [15:0] i_quat_y,
    input  logic signed [15:0] i_quat_z,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output logic [2:0]   o_status,
    output logic [14:0]  o_forward_speed,
    output logic signed [12:0] o_turn_rate,
    output logic [31:0]  o_distance_left,
    output logic signed [15:0] o_heading_left,
    output logic signed [31:0] o_report_x,
    output logic signed [31:0] o_report_y
);
    import wgtg_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_load;
    logic r_ov;
    logic [2:0] w_st;
    logic [14:0] w_fw;
    logic signed [12:0] w_tr;
    logic [31:0] w_dl;
    logic signed [15:0] w_hl;
    logic signed [31:0] w_rx, w_ry;

    wgtg_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .i_func,
        .i_out_busy (r_ov && !i_out_ready),
        .o_out_load (w_load),
        .i_sts (w_sts), .o_cmd (w_cmd)
    );

    wgtg_dp #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
        .i_clk, .i_rst_n, .i_cmd (w_cmd), .o_sts (w_sts),
        .i_cfg_we, .i_cfg_idx, .i_cfg_data, .i_func,
        .i_pos_x, .i_pos_y, .i_quat_w, .i_quat_x, .i_quat_y, .i_quat_z,
        .o_status (w_st), .o_forward_speed (w_fw), .o_turn_rate (w_tr),
        .o_distance_left (w_dl), .o_heading_left (w_hl),
        .o_report_x (w_rx), .o_report_y (w_ry)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_load) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            o_status <= w_st; o_forward_speed <= w_fw; o_turn_rate <= w_tr;
            o_distance_left <= w_dl; o_heading_left <= w_hl;
            o_report_x <= w_rx; o_report_y <= w_ry;
        end
    end

    assign o_out_valid = r_ov;

endmodule
